// ----- rtl/gtsf_pkg.sv -----
`default_nettype none
package gtsf_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int CFG_W      = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int NUM_AXES   = 3;

	// divider geometry: numerator < 2^93, divisor < 2^62, 63 quotient bits
	localparam int NUM_W     = 93;
	localparam int DEN_W     = 62;
	localparam int Q_W       = 63;
	localparam int DIV_STEPS = Q_W;
	localparam int DIV_LAT   = DIV_STEPS + 1;

	localparam int W_FRAC = 31;
	localparam logic [31:0] W_ONE = 32'h8000_0000;
	localparam logic [63:0] G_CAP = 64'h8000_0000_0000_0000;

	localparam logic [CFG_W-1:0] CELL_RESET = 31'd65536;

	localparam logic [CFG_IDX_W-1:0] REG_CELL_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_Z = 2'd2;

	typedef enum logic [2:0] {
		RGN_NONE,
		RGN_A,
		RGN_B,
		RGN_C,
		RGN_D,
		RGN_E
	} region_e;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] particle_x;
		logic signed [DATA_WIDTH-1:0] particle_y;
		logic signed [DATA_WIDTH-1:0] particle_z;
		logic signed [DATA_WIDTH-1:0] node_x;
		logic signed [DATA_WIDTH-1:0] node_y;
		logic signed [DATA_WIDTH-1:0] node_z;
		logic [CFG_W-1:0]             half_x;
		logic [CFG_W-1:0]             half_y;
		logic [CFG_W-1:0]             half_z;
		logic                         use_gimp;
	} item_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0]        weight;
		logic signed [DATA_WIDTH-1:0] grad_x;
		logic signed [DATA_WIDTH-1:0] grad_y;
		logic signed [DATA_WIDTH-1:0] grad_z;
	} result_t;

	typedef struct packed {
		region_e region;
		logic    neg;
	} axis_tag_t;

	typedef struct packed {
		region_e     region;
		logic        neg;
		logic [31:0] u;
	} axis_front_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [Q_W-1:0]   nq;
		logic [DEN_W-1:0] den;
		logic             sat;
	} div_state_t;

endpackage
`default_nettype wire

// ----- rtl/gtsf_div.sv -----
`default_nettype none
// pipelined restoring divider, one quotient bit per stage
// sat set when the quotient does not fit in Q_W bits (or divisor is zero)
module gtsf_div import gtsf_pkg::*; (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo,
	output logic             sat
);

	div_state_t stg_s [DIV_STEPS+1];

	always_ff @(posedge clk) begin
		stg_s[0].rem <= DEN_W'(num[NUM_W-1:Q_W]);
		stg_s[0].nq  <= num[Q_W-1:0];
		stg_s[0].den <= den;
		stg_s[0].sat <= {{(DEN_W-(NUM_W-Q_W)){1'b0}}, num[NUM_W-1:Q_W]} >= den;
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic           ge;

		always_comb begin
			trial = {stg_s[k-1].rem, stg_s[k-1].nq[Q_W-1]};
			ge    = trial >= {1'b0, stg_s[k-1].den};
		end

		always_ff @(posedge clk) begin
			stg_s[k].rem <= ge ? DEN_W'(trial - {1'b0, stg_s[k-1].den}) : DEN_W'(trial);
			stg_s[k].nq  <= {stg_s[k-1].nq[Q_W-2:0], ge};
			stg_s[k].den <= stg_s[k-1].den;
			stg_s[k].sat <= stg_s[k-1].sat;
		end
	end

	assign quo = stg_s[DIV_STEPS].nq;
	assign sat = stg_s[DIV_STEPS].sat;

endmodule
`default_nettype wire

// ----- rtl/gimp_tensor_shape_function_unit.sv -----
`default_nettype none
// GIMP / linear MPM tensor-product shape function, one particle-node pair
// per transaction.
//
// Input: raise start with the pair on item; the transaction is taken at any
// rising edge with start high and busy low. busy is never raised, so a new
// pair may follow every cycle (one pair per clock sustained).
// Output: done pulses for exactly one cycle with weight and gradient on
// result, in input order. The
// receiver cannot hold results off; none is dropped.
// Pipeline: 4 front stages (capture, classify, products, numerators), 64
// stages of the bit-per-stage dividers (one precheck stage plus 63 quotient
// bits), 4 back stages (1D values, tensor products, partial products,
// saturation).
// Configuration: cfg_we/cfg_index/cfg_data write the cell sizes x, y, z
// (index 0..2, other indexes ignored). Write only with nothing in flight.
// Reset: arst_n clears all valid bits, so nothing in flight survives; cell
// sizes return to 1.0 (unsigned Q15.16).
module gimp_tensor_shape_function_unit import gtsf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int LATENCY = 8 + DIV_LAT;

	// region search along one axis; first region A..E whose bounds hold wins
	function automatic axis_front_t classify(
		input logic signed [DATA_WIDTH-1:0] p,
		input logic signed [DATA_WIDTH-1:0] n,
		input logic [CFG_W-1:0]             h,
		input logic [CFG_W-1:0]             lp
	);
		axis_front_t       r;
		logic signed [34:0] d;
		logic signed [34:0] sh;
		logic signed [34:0] sl;
		r.region = RGN_NONE;
		r.neg    = 1'b0;
		r.u      = '0;
		d  = 35'(p) - 35'(n);
		sh = $signed({4'b0, h});
		sl = $signed({4'b0, lp});
		if (h != '0) begin
			priority if (d > -sh - sl && d <= -sh + sl) begin
				r.region = RGN_A;
				r.u      = 32'(sh + sl + d);
			end else if (d > -sh + sl && d <= -sl) begin
				r.region = RGN_B;
				r.u      = 32'(sh + d);
			end else if (d > -sl && d <= sl) begin
				r.region = RGN_C;
				r.u      = (d < 0) ? 32'(-d) : 32'(d);
				r.neg    = d > 0;
			end else if (d > sl && d <= sh - sl) begin
				r.region = RGN_D;
				r.u      = 32'(sh - d);
				r.neg    = 1'b1;
			end else if (d > sh - sl && d <= sh + sl) begin
				r.region = RGN_E;
				r.u      = 32'(sh + sl - d);
				r.neg    = 1'b1;
			end else begin
				r.region = RGN_NONE;
			end
		end
		return r;
	endfunction

	// cell size registers
	logic [CFG_W-1:0] cell_q [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q[0] <= CELL_RESET;
			cell_q[1] <= CELL_RESET;
			cell_q[2] <= CELL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CELL_X: cell_q[0] <= cfg_data;
				REG_CELL_Y: cell_q[1] <= cfg_data;
				REG_CELL_Z: cell_q[2] <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign busy = 1'b0;

	// S1: capture the transaction
	logic  valid_s1;
	item_t item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
	end

	logic signed [DATA_WIDTH-1:0] pos_c [NUM_AXES];
	logic signed [DATA_WIDTH-1:0] nod_c [NUM_AXES];
	logic [CFG_W-1:0]             lp_c  [NUM_AXES];

	// linear MPM is GIMP with zero half-size
	always_comb begin
		pos_c[0] = item_s1.particle_x;
		pos_c[1] = item_s1.particle_y;
		pos_c[2] = item_s1.particle_z;
		nod_c[0] = item_s1.node_x;
		nod_c[1] = item_s1.node_y;
		nod_c[2] = item_s1.node_z;
		lp_c[0]  = item_s1.use_gimp ? item_s1.half_x : '0;
		lp_c[1]  = item_s1.use_gimp ? item_s1.half_y : '0;
		lp_c[2]  = item_s1.use_gimp ? item_s1.half_z : '0;
	end

	// S2: region, |d| or distance to the support edge
	logic             valid_s2;
	axis_front_t      front_s2 [NUM_AXES];
	logic [CFG_W-1:0] h_s2     [NUM_AXES];
	logic [CFG_W-1:0] lp_s2    [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else         valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_AXES; i++) begin
			front_s2[i] <= classify(pos_c[i], nod_c[i], cell_q[i], lp_c[i]);
			h_s2[i]     <= cell_q[i];
			lp_s2[i]    <= lp_c[i];
		end
	end

	// S3: squares and h*lp
	logic             valid_s3;
	logic [63:0]      uu_s3  [NUM_AXES];
	logic [DEN_W-1:0] ll_s3  [NUM_AXES];
	logic [DEN_W-1:0] hl_s3  [NUM_AXES];
	logic [31:0]      u_s3   [NUM_AXES];
	logic [CFG_W-1:0] h_s3   [NUM_AXES];
	axis_tag_t        tag_s3 [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else         valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_AXES; i++) begin
			uu_s3[i]         <= 64'(front_s2[i].u) * 64'(front_s2[i].u);
			ll_s3[i]         <= DEN_W'(lp_s2[i]) * DEN_W'(lp_s2[i]);
			hl_s3[i]         <= DEN_W'(h_s2[i]) * DEN_W'(lp_s2[i]);
			u_s3[i]          <= front_s2[i].u;
			h_s3[i]          <= h_s2[i];
			tag_s3[i].region <= front_s2[i].region;
			tag_s3[i].neg    <= front_s2[i].neg;
		end
	end

	// S4: divider operands per region
	logic [NUM_W-1:0] nw_c [NUM_AXES];
	logic [DEN_W-1:0] dw_c [NUM_AXES];
	logic [NUM_W-1:0] ng_c [NUM_AXES];
	logic [DEN_W-1:0] dg_c [NUM_AXES];

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			unique case (tag_s3[i].region)
				RGN_A, RGN_E: begin
					nw_c[i] = NUM_W'(uu_s3[i]) << (W_FRAC - 2);
					dw_c[i] = hl_s3[i];
					ng_c[i] = NUM_W'(u_s3[i]) << (2 * FRAC_BITS - 1);
					dg_c[i] = hl_s3[i];
				end
				RGN_B, RGN_D: begin
					nw_c[i] = NUM_W'(u_s3[i]) << W_FRAC;
					dw_c[i] = DEN_W'(h_s3[i]);
					ng_c[i] = NUM_W'(1) << (2 * FRAC_BITS);
					dg_c[i] = DEN_W'(h_s3[i]);
				end
				RGN_C: begin
					nw_c[i] = (NUM_W'(uu_s3[i]) + NUM_W'(ll_s3[i])) << (W_FRAC - 1);
					dw_c[i] = hl_s3[i];
					ng_c[i] = NUM_W'(u_s3[i]) << (2 * FRAC_BITS);
					dg_c[i] = hl_s3[i];
				end
				default: begin
					nw_c[i] = '0;
					dw_c[i] = DEN_W'(1);
					ng_c[i] = '0;
					dg_c[i] = DEN_W'(1);
				end
			endcase
		end
	end

	logic             valid_s4;
	logic [NUM_W-1:0] nw_s4  [NUM_AXES];
	logic [DEN_W-1:0] dw_s4  [NUM_AXES];
	logic [NUM_W-1:0] ng_s4  [NUM_AXES];
	logic [DEN_W-1:0] dg_s4  [NUM_AXES];
	axis_tag_t        tag_s4 [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else         valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		nw_s4  <= nw_c;
		dw_s4  <= dw_c;
		ng_s4  <= ng_c;
		dg_s4  <= dg_c;
		tag_s4 <= tag_s3;
	end

	// dividers: weight quotient and slope quotient per axis
	logic [Q_W-1:0] qw [NUM_AXES];
	logic           sw [NUM_AXES];
	logic [Q_W-1:0] qg [NUM_AXES];
	logic           sg [NUM_AXES];

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		gtsf_div u_div_w (
			.clk (clk),
			.num (nw_s4[a]),
			.den (dw_s4[a]),
			.quo (qw[a]),
			.sat (sw[a])
		);
		gtsf_div u_div_g (
			.clk (clk),
			.num (ng_s4[a]),
			.den (dg_s4[a]),
			.quo (qg[a]),
			.sat (sg[a])
		);
	end

	// region tags and valid bits ride alongside the dividers
	axis_tag_t tagline_q [DIV_LAT][NUM_AXES];
	logic      vldline_q [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) vldline_q[k] <= 1'b0;
		end else begin
			vldline_q[0] <= valid_s4;
			for (int k = 1; k < DIV_LAT; k++) vldline_q[k] <= vldline_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		tagline_q[0] <= tag_s4;
		for (int k = 1; k < DIV_LAT; k++) tagline_q[k] <= tagline_q[k-1];
	end

	// S5: 1D weight (capped at 1.0, region C is 1 - q) and slope magnitude
	logic [31:0] wq_c [NUM_AXES];
	logic [31:0] w_c  [NUM_AXES];
	logic [63:0] g_c  [NUM_AXES];

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			wq_c[i] = (sw[i] || qw[i] > Q_W'(W_ONE)) ? W_ONE : qw[i][31:0];
			unique case (tagline_q[DIV_LAT-1][i].region)
				RGN_NONE: begin
					w_c[i] = '0;
					g_c[i] = '0;
				end
				RGN_C: begin
					w_c[i] = W_ONE - wq_c[i];
					g_c[i] = sg[i] ? G_CAP : {1'b0, qg[i]};
				end
				default: begin
					w_c[i] = wq_c[i];
					g_c[i] = sg[i] ? G_CAP : {1'b0, qg[i]};
				end
			endcase
		end
	end

	logic        valid_s5;
	logic [31:0] w_s5   [NUM_AXES];
	logic [63:0] g_s5   [NUM_AXES];
	logic        neg_s5 [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s5 <= 1'b0;
		else         valid_s5 <= vldline_q[DIV_LAT-1];
	end

	always_ff @(posedge clk) begin
		w_s5 <= w_c;
		g_s5 <= g_c;
		for (int i = 0; i < NUM_AXES; i++) neg_s5[i] <= tagline_q[DIV_LAT-1][i].neg;
	end

	// S6: pairwise products of the other two axes' weights
	logic [63:0] pp_c [NUM_AXES];

	always_comb begin
		pp_c[0] = 64'(w_s5[1]) * 64'(w_s5[2]);
		pp_c[1] = 64'(w_s5[0]) * 64'(w_s5[2]);
		pp_c[2] = 64'(w_s5[0]) * 64'(w_s5[1]);
	end

	logic        valid_s6;
	logic [31:0] p_s6   [NUM_AXES];
	logic [31:0] w2_s6;
	logic [63:0] g_s6   [NUM_AXES];
	logic        neg_s6 [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s6 <= 1'b0;
		else         valid_s6 <= valid_s5;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_AXES; i++) p_s6[i] <= pp_c[i][62:31];
		w2_s6  <= w_s5[2];
		g_s6   <= g_s5;
		neg_s6 <= neg_s5;
	end

	// S7: weight and split slope x product partial products
	logic [63:0] wt_c;

	assign wt_c = 64'(p_s6[2]) * 64'(w2_s6);

	logic        valid_s7;
	logic [31:0] wt_s7;
	logic [63:0] glo_s7 [NUM_AXES];
	logic [63:0] ghi_s7 [NUM_AXES];
	logic        neg_s7 [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s7 <= 1'b0;
		else         valid_s7 <= valid_s6;
	end

	always_ff @(posedge clk) begin
		wt_s7 <= wt_c[62:31];
		for (int i = 0; i < NUM_AXES; i++) begin
			glo_s7[i] <= 64'(g_s6[i][31:0]) * 64'(p_s6[i]);
			ghi_s7[i] <= 64'(g_s6[i][63:32]) * 64'(p_s6[i]);
		end
		neg_s7 <= neg_s6;
	end

	// S8: recombine, scale by 2^-31, saturate, apply sign
	logic [95:0] full_c [NUM_AXES];
	logic [64:0] mag_c  [NUM_AXES];
	logic [64:0] cap_c  [NUM_AXES];
	logic [31:0] m_c    [NUM_AXES];
	logic [31:0] gout_c [NUM_AXES];

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			full_c[i] = {ghi_s7[i], 32'b0} + {32'b0, glo_s7[i]};
			mag_c[i]  = full_c[i][95:31];
			cap_c[i]  = neg_s7[i] ? 65'(W_ONE) : 65'(W_ONE - 32'd1);
			m_c[i]    = (mag_c[i] > cap_c[i]) ? cap_c[i][31:0] : mag_c[i][31:0];
			gout_c[i] = neg_s7[i] ? (32'd0 - m_c[i]) : m_c[i];
		end
	end

	logic    done_s8;
	result_t result_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_s8 <= 1'b0;
		else         done_s8 <= valid_s7;
	end

	always_ff @(posedge clk) begin
		result_s8.weight <= wt_s7;
		result_s8.grad_x <= gout_c[0];
		result_s8.grad_y <= gout_c[1];
		result_s8.grad_z <= gout_c[2];
	end

	assign done   = done_s8;
	assign result = result_s8;

	// every result traces back to one input transaction a fixed time ago
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching input transaction");

	a_axis_weight_cap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (w_s5[0] <= W_ONE && w_s5[1] <= W_ONE && w_s5[2] <= W_ONE))
		else $error("1D weight above 1.0");

	a_weight_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.weight <= W_ONE)
		else $error("tensor weight above 1.0");

endmodule
`default_nettype wire
